@@ design/mp2_pkg.sv @@
// Package for the 2x2 stride-2 max pooling stream unit.
// Holds the value width, the position and result records, and the signed maximum.
// Used by mp2_position, mp2_window and max_pool_2x2_stream_unit.
package mp2_pkg;

  localparam int VALUE_W   = 16;
  localparam int CHAN_W    = 4;
  localparam int POOLED_W  = 3;
  localparam int OUT_DATA_W = 32;

  typedef logic [VALUE_W-1:0] value_t;

  typedef struct packed {
    logic                odd_col;
    logic                odd_row;
    logic                last;
    logic [CHAN_W-1:0]   channel;
    logic [POOLED_W-1:0] prow;
    logic [POOLED_W-1:0] pcol;
  } pos_t;

  typedef struct packed {
    value_t              max_value;
    logic [CHAN_W-1:0]   channel;
    logic [POOLED_W-1:0] prow;
    logic [POOLED_W-1:0] pcol;
    logic                last;
  } res_t;

  function automatic value_t smax(value_t a, value_t b);
    logic signed [VALUE_W-1:0] sa;
    logic signed [VALUE_W-1:0] sb;
    sa = a;
    sb = b;
    return (sa >= sb) ? a : b;
  endfunction

endpackage

@@ design/max_pool_2x2_stream_unit.sv @@
// Top level of the 2x2 stride-2 max pooling stream unit.
// Instantiates mp2_position and mp2_window and holds the result register.
// Depends on mp2_pkg.
//
//   port group   dir  tdata fields (low bit first)                 tlast
//   s_axis       in   feature_value[15:0]                          -
//   m_axis       out  max_value[15:0] channel_index[19:16]          frame_last
//                     pooled_row[22:20] pooled_col[25:23], zeros
//
// One item is accepted per cycle unless a held result stalls the window stage.
// A result is registered in the window stage, then in the output register. The rate
// is set by one read of each memory at accept and one previous-row write in the window
// stage, both single-ported per cycle. Reset clears the counters and valid flags;
// memory contents need no clearing. A stalled result holds in the output register
// while the window stage keeps taking items that produce no result.
module max_pool_2x2_stream_unit #(
  parameter int CHANNELS     = 16,
  parameter int FRAME_WIDTH  = 10,
  parameter int FRAME_HEIGHT = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // feature_value
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // max_value, channel_index, pooled_row, pooled_col
  output logic        m_axis_tlast
);
  import mp2_pkg::*;

  localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int PR_DEPTH = CHANNELS * (FRAME_WIDTH / 2);
  localparam int PR_AW    = (PR_DEPTH > 1) ? $clog2(PR_DEPTH) : 1;

  pos_t             pos;
  logic [CH_W-1:0]  ch_idx;
  logic [PR_AW-1:0] pr_addr;
  logic             in_accept;
  logic             s1_valid;
  logic             s1_emit;
  logic             s1_adv;
  res_t             res;
  res_t             out_res;

  assign s1_adv        = s1_valid && (!s1_emit || !m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !s1_valid || s1_adv;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  mp2_position #(
    .CHANNELS     (CHANNELS),
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT),
    .CH_W         (CH_W),
    .PR_AW        (PR_AW)
  ) u_position (
    .clk     (clk),
    .rst     (rst),
    .advance (in_accept),
    .pos     (pos),
    .ch_idx  (ch_idx),
    .pr_addr (pr_addr)
  );

  mp2_window #(
    .CHANNELS    (CHANNELS),
    .FRAME_WIDTH (FRAME_WIDTH),
    .CH_W        (CH_W),
    .PR_AW       (PR_AW)
  ) u_window (
    .clk       (clk),
    .rst       (rst),
    .in_accept (in_accept),
    .in_value  (s_axis_tdata),
    .pos       (pos),
    .ch_idx    (ch_idx),
    .pr_addr   (pr_addr),
    .s1_adv    (s1_adv),
    .s1_valid  (s1_valid),
    .s1_emit   (s1_emit),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (s1_adv && s1_emit) begin
      out_res <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (s1_adv && s1_emit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  assign m_axis_tdata = {6'b0, out_res.pcol, out_res.prow, out_res.channel,
                         out_res.max_value};
  assign m_axis_tlast = out_res.last;

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_adv |-> !s_axis_tready)
    else $error("input accepted while the window stage is stalled");

  a_last_channel: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast |-> out_res.channel == CHAN_W'(CHANNELS - 1))
    else $error("frame end marked on a channel other than the last");

  a_last_row: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast |-> out_res.prow == POOLED_W'(FRAME_HEIGHT / 2 - 1))
    else $error("frame end marked on a pooled row other than the last");

  a_result_drains: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && !(s1_adv && s1_emit) |=> !m_axis_tvalid)
    else $error("result still shown after it was taken");

endmodule

@@ design/mp2_position.sv @@
// Position counters for the pooling unit: channel, column, row and the
// previous-row store address of the next item. Depends on mp2_pkg.
module mp2_position #(
  parameter int CHANNELS     = 16,
  parameter int FRAME_WIDTH  = 10,
  parameter int FRAME_HEIGHT = 10,
  parameter int CH_W         = 4,
  parameter int PR_AW        = 7
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  output mp2_pkg::pos_t     pos,
  output logic [CH_W-1:0]   ch_idx,
  output logic [PR_AW-1:0]  pr_addr
);
  import mp2_pkg::*;

  localparam int COL_W    = (FRAME_WIDTH > 1) ? $clog2(FRAME_WIDTH) : 1;
  localparam int ROW_W    = (FRAME_HEIGHT > 1) ? $clog2(FRAME_HEIGHT) : 1;
  localparam int ROW_LAST = 2 * (FRAME_HEIGHT / 2) - 1;
  localparam int COL_LAST = 2 * (FRAME_WIDTH / 2) - 1;

  logic [CH_W-1:0]  ch;
  logic [CH_W-1:0]  ch_next;
  logic [COL_W-1:0] col;
  logic [COL_W-1:0] col_next;
  logic [ROW_W-1:0] row;
  logic [ROW_W-1:0] row_next;
  logic [PR_AW-1:0] addr;
  logic [PR_AW-1:0] addr_next;
  logic             ch_wrap;
  logic             col_wrap;

  always_comb begin
    ch_wrap   = (ch == CH_W'(CHANNELS - 1));
    col_wrap  = (col == COL_W'(FRAME_WIDTH - 1));
    ch_next   = ch_wrap ? '0 : ch + 1'b1;
    col_next  = col;
    row_next  = row;
    addr_next = addr;
    if (col[0]) begin
      addr_next = addr + 1'b1;
    end
    if (ch_wrap) begin
      col_next = col_wrap ? '0 : col + 1'b1;
      if (col_wrap) begin
        addr_next = '0;
        row_next  = (row == ROW_W'(FRAME_HEIGHT - 1)) ? '0 : row + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ch   <= '0;
      col  <= '0;
      row  <= '0;
      addr <= '0;
    end else if (advance) begin
      ch   <= ch_next;
      col  <= col_next;
      row  <= row_next;
      addr <= addr_next;
    end
  end

  always_comb begin
    pos.odd_col = col[0];
    pos.odd_row = row[0];
    pos.last    = (row == ROW_W'(ROW_LAST)) && (col == COL_W'(COL_LAST)) &&
                  ch_wrap;
    pos.channel = CHAN_W'(ch);
    pos.prow    = POOLED_W'(row >> 1);
    pos.pcol    = POOLED_W'(col >> 1);
    ch_idx      = ch;
    pr_addr     = addr;
  end

endmodule

@@ design/mp2_window.sv @@
// Window stage of the pooling unit: left-neighbor and previous-row memories,
// the stage register and the two signed compares. Depends on mp2_pkg.
module mp2_window #(
  parameter int CHANNELS    = 16,
  parameter int FRAME_WIDTH = 10,
  parameter int CH_W        = 4,
  parameter int PR_AW       = 7
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_accept,
  input  mp2_pkg::value_t   in_value,
  input  mp2_pkg::pos_t     pos,
  input  logic [CH_W-1:0]   ch_idx,
  input  logic [PR_AW-1:0]  pr_addr,
  input  logic              s1_adv,
  output logic              s1_valid,
  output logic              s1_emit,
  output mp2_pkg::res_t     res
);
  import mp2_pkg::*;

  localparam int PR_DEPTH = CHANNELS * (FRAME_WIDTH / 2);

  value_t           left_mem [CHANNELS];
  value_t           prev_mem [PR_DEPTH];
  value_t           left_rd;
  value_t           prev_rd;
  value_t           s1_value;
  pos_t             s1_pos;
  logic [PR_AW-1:0] s1_addr;
  value_t           pair;

  always_ff @(posedge clk) begin
    if (in_accept && !pos.odd_col) begin
      left_mem[ch_idx] <= in_value;
    end
    if (in_accept && pos.odd_col) begin
      left_rd <= left_mem[ch_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && pos.odd_col && pos.odd_row) begin
      prev_rd <= prev_mem[pr_addr];
    end
    if (s1_valid && s1_adv && s1_pos.odd_col && !s1_pos.odd_row) begin
      prev_mem[s1_addr] <= pair;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_value <= in_value;
      s1_pos   <= pos;
      s1_addr  <= pr_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_comb begin
    pair          = smax(left_rd, s1_value);
    s1_emit       = s1_valid && s1_pos.odd_col && s1_pos.odd_row;
    res.max_value = smax(prev_rd, pair);
    res.channel   = s1_pos.channel;
    res.prow      = s1_pos.prow;
    res.pcol      = s1_pos.pcol;
    res.last      = s1_pos.last;
  end

endmodule

@@ test/tb.sv @@
// Testbench for max_pool_2x2_stream_unit: streams feature values and checks every pooled result.
// A scoreboard class predicts each 2x2 window maximum and compares it field by field.
// Depends on mp2_pkg and the design files.
`timescale 1ns / 1ps

module tb;
  import mp2_pkg::*;

  localparam int CH = 16;
  localparam int FW = 10;
  localparam int FH = 10;
  localparam int ROW_ITEMS = CH * FW;
  localparam int FRAME_ITEMS = ROW_ITEMS * FH;
  localparam int DIRECTED_ITEMS = 25;
  // The stimulus covers the first five rows of a frame, so every channel and every pooled
  // column is exercised over two pooled rows.
  localparam int TOTAL_ITEMS = 5 * ROW_ITEMS;
  localparam int IDLE_PCT = 13;
  localparam int HOLD_AT_ITEM = 400;
  localparam int HOLD_CYCLES = 300;
  localparam int CALM_FIRST = 500;
  localparam int CALM_LAST = 700;
  localparam int DRAIN_CYCLES = 10;

  class pool_scoreboard;
    value_t row_pair_max [CH*FW];
    value_t left_value [CH];
    int chan_pos;
    int col_pos;
    int row_pos;
    res_t window_max_q [$];
    int items_seen;
    int results_checked;
    int frame_ends;
    int mismatches;

    function new();
      chan_pos = 0;
      col_pos = 0;
      row_pos = 0;
      items_seen = 0;
      results_checked = 0;
      frame_ends = 0;
      mismatches = 0;
    endfunction

    function value_t larger(value_t a, value_t b);
      logic signed [VALUE_W-1:0] sa;
      logic signed [VALUE_W-1:0] sb;
      sa = a;
      sb = b;
      if (sa >= sb) return a;
      return b;
    endfunction

    function void note_item(value_t v);
      value_t pair;
      res_t r;
      int slot;
      slot = col_pos * CH + chan_pos;
      items_seen++;
      if (col_pos % 2 == 1) begin
        pair = larger(left_value[chan_pos], v);
        if (row_pos % 2 == 0) begin
          row_pair_max[slot] = pair;
        end else begin
          r.max_value = larger(row_pair_max[slot], pair);
          r.channel = chan_pos[CHAN_W-1:0];
          r.prow = row_pos[POOLED_W:1];
          r.pcol = col_pos[POOLED_W:1];
          r.last = (row_pos / 2 == FH / 2 - 1) && (col_pos / 2 == FW / 2 - 1) &&
                   (chan_pos == CH - 1);
          window_max_q.push_back(r);
        end
      end
      left_value[chan_pos] = v;
      chan_pos++;
      if (chan_pos == CH) begin
        chan_pos = 0;
        col_pos++;
        if (col_pos == FW) begin
          col_pos = 0;
          row_pos++;
          if (row_pos == FH) row_pos = 0;
        end
      end
    endfunction

    task report_mismatch(string what, longint got, longint want);
      mismatches++;
      $display("%0t mismatch on result %0d: %s got %0h want %0h",
               $time, results_checked, what, got, want);
    endtask

    task check_result(logic [31:0] data, logic last);
      res_t want;
      if (window_max_q.size() == 0) begin
        report_mismatch("unexpected result, tdata", data, 0);
      end else begin
        want = window_max_q.pop_front();
        if (data[15:0] !== want.max_value) report_mismatch("max_value", data[15:0], want.max_value);
        if (data[19:16] !== want.channel) report_mismatch("channel_index", data[19:16], want.channel);
        if (data[22:20] !== want.prow) report_mismatch("pooled_row", data[22:20], want.prow);
        if (data[25:23] !== want.pcol) report_mismatch("pooled_col", data[25:23], want.pcol);
        if (data[31:26] !== '0) report_mismatch("tdata padding", data[31:26], 0);
        if (last !== want.last) report_mismatch("frame_last", last, want.last);
        if (want.last) frame_ends++;
      end
      results_checked++;
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic m_axis_tlast;

  pool_scoreboard board;
  int hold_left = 0;
  bit hold_done = 1'b0;

  max_pool_2x2_stream_unit #(
    .CHANNELS(CH),
    .FRAME_WIDTH(FW),
    .FRAME_HEIGHT(FH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tlast(m_axis_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit calm_stretch();
    return board.items_seen >= CALM_FIRST && board.items_seen < CALM_LAST;
  endfunction

  function automatic value_t random_value();
    value_t corners [6] = '{16'h8000, 16'h7FFF, 16'h8001, 16'h7FFE, 16'h0000, 16'hFFFF};
    int pick;
    pick = $urandom_range(99);
    if (pick < 40) return value_t'($urandom);
    if (pick < 75) return value_t'($urandom_range(6) - 3);
    return corners[$urandom_range(5)];
  endfunction

  task automatic send_item(value_t v);
    while (!calm_stretch() && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= v;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    board.note_item(v);
  endtask

  initial begin
    value_t directed [DIRECTED_ITEMS] = '{
      16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h0001, 16'h8001, 16'h7FFE, 16'hFFFE,
      16'h5555, 16'hAAAA, 16'h00FF, 16'hFF00, 16'h8000, 16'h7FFF, 16'h0000, 16'h0000,
      16'h8000, 16'h7FFF, 16'hFFFF, 16'h0000, 16'h8001, 16'hFFFF, 16'h7FFE, 16'hAAAA,
      16'h5555};
    board = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    foreach (directed[i]) send_item(directed[i]);
    while (board.items_seen < TOTAL_ITEMS) send_item(random_value());
    s_axis_tvalid <= 1'b0;
    while (board.window_max_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Streamed %0d items over %0d pooled results, %0d frame end(s) seen.",
             board.items_seen, board.results_checked, board.frame_ends);
    $display("Values included both signed extremes, ties near zero and a long output stall.");
    if (board.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", board.mismatches);
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata, m_axis_tlast);
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (!hold_done && board.items_seen >= HOLD_AT_ITEM) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= calm_stretch() || $urandom_range(99) >= IDLE_PCT;
      end
    end
  end

  initial begin
    #2000000;
    $display("Timeout with %0d results still expected.", board.window_max_q.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
